### hdl/priority_message_effect_scheduler_assert.svh
// assertion macros for the priority message effect scheduler
`ifndef PRIORITY_MESSAGE_EFFECT_SCHEDULER_ASSERT_SVH
`define PRIORITY_MESSAGE_EFFECT_SCHEDULER_ASSERT_SVH

// clocked implication check, disabled in reset
`define PMES_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

### hdl/pmes_pkg.sv
// types, codes and constants of the priority message effect scheduler
`timescale 1ns / 1ps

package pmes_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TIME_W = 48;
    localparam int DUR_W  = 32;
    localparam int DVS_W  = 32;
    localparam int CYC_W  = 23;
    localparam int POS_W  = 14;
    localparam int SHIFT_W = 13;
    localparam int MS_PER_S = 1000;
    localparam int MUL_W  = CYC_W + 16;
    localparam int RECIP_W = 24;
    localparam int PROD_W = CYC_W + RECIP_W;
    localparam int RECIP_SH = 33;
    // ceil(2^33 / 1000), exact for products below 2^23
    localparam logic [RECIP_W-1:0] RECIP_MS = 24'd8589935;

    typedef logic [SLOT_W-1:0] slot_idx_t;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_SET  = 2'd1;
    localparam logic [1:0] MODE_BG   = 2'd2;

    localparam logic [1:0] EFF_STATIC = 2'd0;
    localparam logic [1:0] EFF_RAW    = 2'd1;
    localparam logic [1:0] EFF_FLASH  = 2'd2;
    localparam logic [1:0] EFF_SCROLL = 2'd3;

    localparam logic [1:0] ALN_LEFT   = 2'd0;
    localparam logic [1:0] ALN_RIGHT  = 2'd1;
    localparam logic [1:0] ALN_CENTRE = 2'd2;

    localparam logic CFG_MAX_BRIGHT = 1'b0;
    localparam logic CFG_DISP_W     = 1'b1;

    typedef struct packed {
        logic [7:0]  bright;
        logic [1:0]  eff;
        logic [1:0]  aln;
        logic        dir;
        logic [15:0] param;
        logic [11:0] tw;
    } look_t;

    typedef struct packed {
        logic [TIME_W-1:0] set_ms;
        logic [DUR_W-1:0]  duration;
        look_t             look;
    } slot_entry_t;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [TIME_W-1:0] quot;
        logic [DVS_W-1:0]  rem;
    } div_rsp_t;

endpackage

### hdl/pmes_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps

interface pmes_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [47:0] time_ms;
    logic [3:0]  priority_req;
    logic [31:0] duration_ms;
    logic [7:0]  brightness;
    logic [1:0]  effect;
    logic [1:0]  align;
    logic        direction;
    logic [15:0] effect_param;
    logic [11:0] text_width;

    modport source (output valid, mode, time_ms, priority_req, duration_ms, brightness,
                    effect, align, direction, effect_param, text_width, input ready);
    modport sink (input valid, mode, time_ms, priority_req, duration_ms, brightness,
                  effect, align, direction, effect_param, text_width, output ready);
endinterface

interface pmes_res_if;
    logic               valid;
    logic               ready;
    logic               from_background;
    logic [3:0]         shown_slot;
    logic [7:0]         out_brightness;
    logic [1:0]         out_effect;
    logic signed [12:0] x_position;
    logic               inverse;

    modport source (output valid, from_background, shown_slot, out_brightness, out_effect,
                    x_position, inverse, input ready);
    modport sink (input valid, from_background, shown_slot, out_brightness, out_effect,
                  x_position, inverse, output ready);
endinterface

### hdl/priority_message_effect_scheduler.sv
// top level of the priority message effect scheduler
// Usage:
// - cmd channel carries one request per handshake (valid and ready high at a clock edge).
//   mode 1 stores a slot record, mode 2 the background record; neither gives
//   a result. mode 0 is a tick and gives exactly one result on res.
// - cfg_wr_en / cfg_index / cfg_data write max_brightness (index 0) and
//   display_width (index 1); the user must write them only while the block is
//   idle, which the block itself does not enforce.
// - a tick scans slots from the highest one down through the single memory read
//   port; a valid slot takes ST_SCAN_RD and ST_SCAN_CHK, an empty one ST_SCAN_RD.
// - static and raw effects then finish directly; flashing runs at most one pass
//   of the shared 48 step divider; scrolling runs up to two passes and then a
//   reciprocal step for the millisecond scale.
// - cmd.ready is high only while no tick is in progress.
// - the result sits in an output register; a following request is taken while it
//   waits, and a later tick holds its result until res.ready frees the register.
// - reset clears all slot valid bits, the background record, the output valid bit,
//   and loads max_brightness 255 and display_width 96.
`timescale 1ns / 1ps

`include "priority_message_effect_scheduler_assert.svh"

module priority_message_effect_scheduler (
    input  logic       clk,
    input  logic       rst_n,
    pmes_cmd_if.sink   cmd,
    pmes_res_if.source res,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [9:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_CALC,
        ST_DIV_FLASH,
        ST_MUL_SPAN,
        ST_DIV_CYCLE,
        ST_DIV_MOD,
        ST_DIV_SHIFT,
        ST_DONE
    } state_t;

    state_t                          state_reg;
    logic [pmes_pkg::SLOTS-1:0]      slot_valid_reg;
    logic [7:0]                      max_bright_reg;
    logic [9:0]                      disp_w_reg;
    logic [pmes_pkg::TIME_W-1:0]     bg_added_reg;
    pmes_pkg::look_t                 bg_look_reg;
    logic [pmes_pkg::TIME_W-1:0]     now_reg;
    pmes_pkg::slot_idx_t             scan_reg;
    pmes_pkg::look_t                 look_reg;
    logic [pmes_pkg::TIME_W-1:0]     added_reg;
    logic                            bg_sel_reg;
    logic [3:0]                      slot_reg;
    logic signed [pmes_pkg::POS_W-1:0] x_reg;
    logic                            inv_reg;
    logic                            div_start_reg;
    logic [pmes_pkg::TIME_W-1:0]     dvd_reg;
    logic [pmes_pkg::DVS_W-1:0]      dvs_reg;
    logic                            out_valid_reg;
    logic                            out_bg_reg;
    logic [3:0]                      out_slot_reg;
    logic [7:0]                      out_bright_reg;
    logic [1:0]                      out_eff_reg;
    logic signed [12:0]              out_x_reg;
    logic                            out_inv_reg;

    logic                            cmd_acc;
    logic                            set_ok;
    pmes_pkg::slot_idx_t             set_idx;
    pmes_pkg::look_t                 in_look;
    pmes_pkg::slot_entry_t           wr_entry;
    pmes_pkg::slot_entry_t           rd_entry;
    pmes_pkg::div_rsp_t              div_rsp;
    logic [pmes_pkg::TIME_W-1:0]     elapsed;
    logic signed [pmes_pkg::POS_W-1:0] w_s;
    logic signed [pmes_pkg::POS_W-1:0] tw_s;
    logic signed [pmes_pkg::POS_W-1:0] diff_s;
    logic signed [pmes_pkg::POS_W-1:0] aligned_x;
    logic signed [pmes_pkg::POS_W-1:0] start_x;
    logic [pmes_pkg::POS_W-1:0]      span;
    logic signed [pmes_pkg::POS_W-1:0] shift_s;
    logic [pmes_pkg::PROD_W-1:0]     recip_prod;
    logic                            expired;
    logic                            res_free;
    logic                            div_go;
    logic                            out_load;

    assign cmd_acc   = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign res_free  = !out_valid_reg || res.ready;
    assign out_load  = (state_reg == ST_DONE) && res_free;
    assign set_ok    = (32'(cmd.priority_req) < pmes_pkg::SLOTS);
    assign set_idx   = pmes_pkg::slot_idx_t'(cmd.priority_req);

    assign in_look.bright = cmd.brightness;
    assign in_look.eff    = cmd.effect;
    assign in_look.aln    = cmd.align;
    assign in_look.dir    = cmd.direction;
    assign in_look.param  = cmd.effect_param;
    assign in_look.tw     = cmd.text_width;

    assign wr_entry.set_ms   = cmd.time_ms;
    assign wr_entry.duration = cmd.duration_ms;
    assign wr_entry.look     = in_look;

    pmes_slot_store u_store (
        .clk     (clk),
        .wr_en   (cmd_acc && (cmd.mode == pmes_pkg::MODE_SET) && set_ok),
        .wr_addr (set_idx),
        .wr_data (wr_entry),
        .rd_addr (scan_reg),
        .rd_data (rd_entry)
    );

    pmes_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .rsp      (div_rsp)
    );

    assign expired = ({1'b0, rd_entry.set_ms} + {17'd0, rd_entry.duration})
                     < {1'b0, now_reg};
    assign elapsed = now_reg - added_reg;
    assign w_s     = pmes_pkg::POS_W'(disp_w_reg);
    assign tw_s    = pmes_pkg::POS_W'(look_reg.tw);
    assign diff_s  = w_s - tw_s;
    assign span    = pmes_pkg::POS_W'(look_reg.tw) + pmes_pkg::POS_W'(disp_w_reg);
    assign start_x = look_reg.dir ? w_s : -tw_s;
    // divide by 1000 through a reciprocal multiply
    assign recip_prod = pmes_pkg::PROD_W'(dvd_reg[pmes_pkg::CYC_W-1:0])
                        * pmes_pkg::PROD_W'(pmes_pkg::RECIP_MS);
    assign shift_s = pmes_pkg::POS_W'(recip_prod[pmes_pkg::RECIP_SH +: pmes_pkg::SHIFT_W]);

    always_comb
    begin
        case (look_reg.aln)
            pmes_pkg::ALN_RIGHT:  aligned_x = diff_s;
            pmes_pkg::ALN_CENTRE: aligned_x = (diff_s + ((diff_s < 0) ? 14'sd1 : 14'sd0)) >>> 1;
            default:              aligned_x = '0;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            ST_CALC:      div_go = (look_reg.eff == pmes_pkg::EFF_FLASH)
                                   && (look_reg.param != '0);
            ST_MUL_SPAN:  div_go = 1'b1;
            ST_DIV_CYCLE: div_go = div_rsp.done && (div_rsp.quot != '0);
            default:      div_go = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_valid_reg <= '0;
            max_bright_reg <= 8'd255;
            disp_w_reg     <= 10'd96;
            bg_added_reg   <= '0;
            bg_look_reg    <= '0;
            div_start_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            div_start_reg <= div_go;
            out_valid_reg <= out_load || (out_valid_reg && !res.ready);
            if (cfg_wr_en)
            begin
                if (cfg_index == pmes_pkg::CFG_MAX_BRIGHT)
                begin
                    max_bright_reg <= cfg_data[7:0];
                end
                else
                begin
                    disp_w_reg <= cfg_data;
                end
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_acc)
                    begin
                        now_reg  <= cmd.time_ms;
                        scan_reg <= pmes_pkg::slot_idx_t'(pmes_pkg::SLOTS - 1);
                        case (cmd.mode)
                            pmes_pkg::MODE_TICK: state_reg <= ST_SCAN_RD;
                            pmes_pkg::MODE_SET:
                            begin
                                if (set_ok)
                                begin
                                    slot_valid_reg[set_idx] <= 1'b1;
                                end
                            end
                            pmes_pkg::MODE_BG:
                            begin
                                bg_added_reg <= cmd.time_ms;
                                bg_look_reg  <= in_look;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN_RD:
                begin
                    if (slot_valid_reg[scan_reg])
                    begin
                        state_reg <= ST_SCAN_CHK;
                    end
                    else if (scan_reg == '0)
                    begin
                        look_reg   <= bg_look_reg;
                        added_reg  <= bg_added_reg;
                        bg_sel_reg <= 1'b1;
                        slot_reg   <= '0;
                        state_reg  <= ST_CALC;
                    end
                    else
                    begin
                        scan_reg <= scan_reg - 1'b1;
                    end
                end
                ST_SCAN_CHK:
                begin
                    if (expired)
                    begin
                        slot_valid_reg[scan_reg] <= 1'b0;
                        if (scan_reg == '0)
                        begin
                            look_reg   <= bg_look_reg;
                            added_reg  <= bg_added_reg;
                            bg_sel_reg <= 1'b1;
                            slot_reg   <= '0;
                            state_reg  <= ST_CALC;
                        end
                        else
                        begin
                            scan_reg  <= scan_reg - 1'b1;
                            state_reg <= ST_SCAN_RD;
                        end
                    end
                    else
                    begin
                        look_reg   <= rd_entry.look;
                        added_reg  <= rd_entry.set_ms;
                        bg_sel_reg <= 1'b0;
                        slot_reg   <= 4'(scan_reg);
                        state_reg  <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    inv_reg <= 1'b0;
                    case (look_reg.eff)
                        pmes_pkg::EFF_STATIC:
                        begin
                            x_reg     <= aligned_x;
                            state_reg <= ST_DONE;
                        end
                        pmes_pkg::EFF_FLASH:
                        begin
                            x_reg <= aligned_x;
                            if (look_reg.param == '0)
                            begin
                                state_reg <= ST_DONE;
                            end
                            else
                            begin
                                dvd_reg   <= elapsed;
                                dvs_reg   <= pmes_pkg::DVS_W'(look_reg.param);
                                state_reg <= ST_DIV_FLASH;
                            end
                        end
                        pmes_pkg::EFF_SCROLL:
                        begin
                            x_reg     <= start_x;
                            state_reg <= (look_reg.param == '0) ? ST_DONE : ST_MUL_SPAN;
                        end
                        default:
                        begin
                            x_reg     <= '0;
                            state_reg <= ST_DONE;
                        end
                    endcase
                end
                ST_DIV_FLASH:
                begin
                    if (div_rsp.done)
                    begin
                        inv_reg   <= div_rsp.quot[0];
                        state_reg <= ST_DONE;
                    end
                end
                ST_MUL_SPAN:
                begin
                    dvd_reg   <= pmes_pkg::TIME_W'(pmes_pkg::CYC_W'(span)
                                                   * pmes_pkg::CYC_W'(pmes_pkg::MS_PER_S));
                    dvs_reg   <= pmes_pkg::DVS_W'(look_reg.param);
                    state_reg <= ST_DIV_CYCLE;
                end
                ST_DIV_CYCLE:
                begin
                    if (div_rsp.done)
                    begin
                        if (div_rsp.quot == '0)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            dvd_reg   <= elapsed;
                            dvs_reg   <= pmes_pkg::DVS_W'(div_rsp.quot[pmes_pkg::CYC_W-1:0]);
                            state_reg <= ST_DIV_MOD;
                        end
                    end
                end
                ST_DIV_MOD:
                begin
                    if (div_rsp.done)
                    begin
                        dvd_reg <= pmes_pkg::TIME_W'(
                                       pmes_pkg::MUL_W'(div_rsp.rem[pmes_pkg::CYC_W-1:0])
                                       * pmes_pkg::MUL_W'(look_reg.param));
                        state_reg <= ST_DIV_SHIFT;
                    end
                end
                ST_DIV_SHIFT:
                begin
                    x_reg     <= look_reg.dir ? (x_reg - shift_s) : (x_reg + shift_s);
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (res_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && res_free)
        begin
            out_bg_reg     <= bg_sel_reg;
            out_slot_reg   <= slot_reg;
            out_bright_reg <= (look_reg.bright > max_bright_reg) ? max_bright_reg
                                                                 : look_reg.bright;
            out_eff_reg    <= look_reg.eff;
            out_x_reg      <= x_reg[12:0];
            out_inv_reg    <= inv_reg;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.from_background = out_bg_reg;
    assign res.shown_slot      = out_slot_reg;
    assign res.out_brightness  = out_bright_reg;
    assign res.out_effect      = out_eff_reg;
    assign res.x_position      = out_x_reg;
    assign res.inverse         = out_inv_reg;

    `PMES_ASSERT(a_ready_div_idle, cmd.ready |-> !div_rsp.busy, "divider busy while ready")
    `PMES_ASSERT(a_bg_slot_zero, (res.valid && res.from_background) |-> (res.shown_slot == 4'd0), "background result with nonzero slot")
    `PMES_ASSERT(a_inv_flash_only, (res.valid && res.inverse) |-> (res.out_effect == pmes_pkg::EFF_FLASH), "inverse without flashing")
    `PMES_ASSERT(a_set_marks_valid, (cmd_acc && (cmd.mode == pmes_pkg::MODE_SET) && set_ok) |=> slot_valid_reg[$past(set_idx)], "set did not mark slot valid")

endmodule

### hdl/pmes_slot_store.sv
// per slot message record memory with registered read
`timescale 1ns / 1ps

module pmes_slot_store (
    input  logic                  clk,
    input  logic                  wr_en,
    input  pmes_pkg::slot_idx_t   wr_addr,
    input  pmes_pkg::slot_entry_t wr_data,
    input  pmes_pkg::slot_idx_t   rd_addr,
    output pmes_pkg::slot_entry_t rd_data
);

    pmes_pkg::slot_entry_t mem [pmes_pkg::SLOTS];
    pmes_pkg::slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/pmes_divider.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module pmes_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pmes_pkg::TIME_W-1:0]  dividend,
    input  logic [pmes_pkg::DVS_W-1:0]   divisor,
    output pmes_pkg::div_rsp_t           rsp
);

    localparam int CNT_W = $clog2(pmes_pkg::TIME_W + 1);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [pmes_pkg::TIME_W-1:0] q_reg, q_next;
    logic [pmes_pkg::DVS_W:0]    r_reg, r_next;
    logic [pmes_pkg::DVS_W-1:0]  d_reg, d_next;
    logic [pmes_pkg::DVS_W:0]    r_try;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        r_try     = {r_reg[pmes_pkg::DVS_W-1:0], q_reg[pmes_pkg::TIME_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(pmes_pkg::TIME_W);
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            if (r_try >= {1'b0, d_reg})
            begin
                r_next = r_try - {1'b0, d_reg};
                q_next = {q_reg[pmes_pkg::TIME_W-2:0], 1'b1};
            end
            else
            begin
                r_next = r_try;
                q_next = {q_reg[pmes_pkg::TIME_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.busy = busy_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg[pmes_pkg::DVS_W-1:0];

endmodule

### sim/priority_message_effect_scheduler_tb.sv
// self-checking testbench for the priority message effect scheduler
`timescale 1ns / 1ps

module priority_message_effect_scheduler_tb;

    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic [1:0]  mode;
        logic [47:0] t;
        logic [3:0]  prio;
        logic [31:0] dur;
        logic [7:0]  bright;
        logic [1:0]  eff;
        logic [1:0]  aln;
        logic        dir;
        logic [15:0] param;
        logic [11:0] tw;
    } request_t;

    typedef struct {
        logic        bg;
        logic [3:0]  slot;
        logic [7:0]  bright;
        logic [1:0]  eff;
        logic [12:0] x;
        logic        inv;
    } shown_t;

    typedef struct {
        request_t req;
        bit       has_fixed;
        shown_t   fixed;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_index;
    logic [9:0] cfg_data;

    pmes_cmd_if cmd ();
    pmes_res_if res ();

    priority_message_effect_scheduler DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd.sink),
        .res(res.source),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor state
    logic [7:0]  max_bright;
    logic [9:0]  disp_w;
    bit          live [pmes_pkg::SLOTS];
    logic [47:0] stamp [pmes_pkg::SLOTS];
    logic [31:0] life [pmes_pkg::SLOTS];
    pmes_pkg::look_t slot_look [pmes_pkg::SLOTS];
    logic [47:0] bg_stamp;
    pmes_pkg::look_t bg_look;

    shown_t expected_shown [$];
    int errors;
    int quiet;
    int send_idle_pct;
    int recv_idle_pct;
    logic [47:0] now_ms;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic pmes_pkg::look_t look_of(request_t r);
        pmes_pkg::look_t k;
        k.bright = r.bright;
        k.eff = r.eff;
        k.aln = r.aln;
        k.dir = r.dir;
        k.param = r.param;
        k.tw = r.tw;
        return k;
    endfunction

    function automatic logic [12:0] placed_x(pmes_pkg::look_t k, int w);
        int tw;
        tw = k.tw;
        if (k.aln == pmes_pkg::ALN_RIGHT)
            return 13'(w - tw);
        if (k.aln == pmes_pkg::ALN_CENTRE)
            return 13'((w - tw) / 2);
        return 13'd0;
    endfunction

    function automatic logic [12:0] scrolled_x(pmes_pkg::look_t k, int w,
                                               longint unsigned el);
        longint unsigned span;
        longint unsigned period;
        longint unsigned shift;
        int tw;
        tw = k.tw;
        span = tw + w;
        shift = 0;
        if (k.param != 0)
        begin
            period = (span * 1000) / k.param;
            if (period != 0)
                shift = ((el % period) * k.param) / 1000;
        end
        if (k.dir == 1'b0)
            return 13'(-tw + int'(shift));
        return 13'(w - int'(shift));
    endfunction

    // apply one accepted request to the predictor
    task automatic predict_request(input request_t r);
        int found;
        pmes_pkg::look_t k;
        longint unsigned el;
        shown_t s;
        found = -1;
        if (r.mode == pmes_pkg::MODE_SET)
        begin
            live[r.prio] = 1'b1;
            stamp[r.prio] = r.t;
            life[r.prio] = r.dur;
            slot_look[r.prio] = look_of(r);
            return;
        end
        if (r.mode == pmes_pkg::MODE_BG)
        begin
            bg_stamp = r.t;
            bg_look = look_of(r);
            return;
        end
        if (r.mode != pmes_pkg::MODE_TICK)
            return;
        for (int i = pmes_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!live[i])
                continue;
            if ({1'b0, stamp[i]} + {17'd0, life[i]} < {1'b0, r.t})
            begin
                live[i] = 1'b0;
                continue;
            end
            found = i;
            break;
        end
        if (found >= 0)
        begin
            k = slot_look[found];
            el = 64'(48'(r.t - stamp[found]));
        end
        else
        begin
            k = bg_look;
            el = 64'(48'(r.t - bg_stamp));
        end
        s.bg = (found < 0);
        s.slot = (found >= 0) ? 4'(found) : 4'd0;
        s.bright = (k.bright > max_bright) ? max_bright : k.bright;
        s.eff = k.eff;
        s.x = 13'd0;
        s.inv = 1'b0;
        case (k.eff)
            pmes_pkg::EFF_STATIC: s.x = placed_x(k, disp_w);
            pmes_pkg::EFF_FLASH:
            begin
                s.x = placed_x(k, disp_w);
                if (k.param != 0)
                    s.inv = 1'((el / k.param) % 2);
            end
            pmes_pkg::EFF_SCROLL: s.x = scrolled_x(k, disp_w, el);
            default: ;
        endcase
        expected_shown.push_back(s);
    endtask

    // result side: random stall, check against oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
            res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        shown_t w;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_shown.size() == 0)
                report("unexpected result", 0, 0);
            else
            begin
                w = expected_shown.pop_front();
                if (res.from_background !== w.bg)
                    report("from_background", res.from_background, w.bg);
                if (res.shown_slot !== w.slot)
                    report("shown_slot", res.shown_slot, w.slot);
                if (res.out_brightness !== w.bright)
                    report("out_brightness", res.out_brightness, w.bright);
                if (res.out_effect !== w.eff)
                    report("out_effect", res.out_effect, w.eff);
                if (res.x_position !== w.x)
                    report("x_position", res.x_position, w.x);
                if (res.inverse !== w.inv)
                    report("inverse", res.inverse, w.inv);
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("priority_message_effect_scheduler_tb: errors");
            $finish;
        end
    end

    task automatic send(input request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.mode <= r.mode;
        cmd.time_ms <= r.t;
        cmd.priority_req <= r.prio;
        cmd.duration_ms <= r.dur;
        cmd.brightness <= r.bright;
        cmd.effect <= r.eff;
        cmd.align <= r.aln;
        cmd.direction <= r.dir;
        cmd.effect_param <= r.param;
        cmd.text_width <= r.tw;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        predict_request(r);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        while (expected_shown.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [9:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == pmes_pkg::CFG_MAX_BRIGHT)
            max_bright = val[7:0];
        else
            disp_w = val;
        @(posedge clk);
    endtask

    function automatic request_t mk(logic [1:0] m, logic [47:0] t, logic [3:0] p,
                                    logic [31:0] d, logic [7:0] b, logic [1:0] e,
                                    logic [1:0] a, logic dr, logic [15:0] pr,
                                    logic [11:0] tw);
        request_t r;
        r.mode = m; r.t = t; r.prio = p; r.dur = d; r.bright = b;
        r.eff = e; r.aln = a; r.dir = dr; r.param = pr; r.tw = tw;
        return r;
    endfunction

    function automatic request_t rand_request();
        request_t r;
        int pick;
        pick = $urandom_range(99);
        r = mk(pmes_pkg::MODE_TICK, now_ms, 4'($urandom), 0, 8'($urandom), 2'($urandom),
               2'($urandom), 1'($urandom), 16'($urandom), 12'($urandom));
        if (pick < 25)
            r.mode = pmes_pkg::MODE_SET;
        else if (pick < 32)
            r.mode = pmes_pkg::MODE_BG;
        else if (pick < 35)
            r.mode = 2'd3;
        r.dur = ($urandom_range(3) == 0) ? 32'($urandom) : 32'($urandom_range(400));
        if ($urandom_range(3) == 0)
            r.param = 16'($urandom_range(40));
        if ($urandom_range(7) == 0)
            r.tw = 12'($urandom_range(8));
        if ($urandom_range(30) == 0)
            r.t = {$urandom, 16'($urandom)};
        return r;
    endfunction

    row_t rows [$];

    initial
    begin
        row_t rw;
        shown_t f;
        errors = 0;
        send_idle_pct = 8;
        recv_idle_pct = 77;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = pmes_pkg::CFG_MAX_BRIGHT;
        cfg_data = '0;
        cmd.valid = 1'b0;
        cmd.mode = pmes_pkg::MODE_TICK;
        cmd.time_ms = '0;
        cmd.priority_req = '0;
        cmd.duration_ms = '0;
        cmd.brightness = '0;
        cmd.effect = pmes_pkg::EFF_STATIC;
        cmd.align = pmes_pkg::ALN_LEFT;
        cmd.direction = 1'b0;
        cmd.effect_param = '0;
        cmd.text_width = '0;
        max_bright = 8'd255;
        disp_w = 10'd96;
        bg_stamp = '0;
        bg_look = '0;
        for (int i = 0; i < pmes_pkg::SLOTS; i++)
            live[i] = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        f = '{1'b1, 4'd0, 8'd0, pmes_pkg::EFF_STATIC, 13'd0, 1'b0};
        rows.push_back('{mk(pmes_pkg::MODE_TICK, 48'd5, 0, 0, 0, 0, 0, 0, 0, 0), 1, f});
        rows.push_back('{mk(pmes_pkg::MODE_BG, 48'd10, 0, 0, 8'd255, pmes_pkg::EFF_STATIC,
                            pmes_pkg::ALN_RIGHT, 0, 0, 12'd4095), 0, f});
        rows.push_back('{mk(pmes_pkg::MODE_TICK, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0),
                         0, f});
        rows.push_back('{mk(pmes_pkg::MODE_SET, 48'd100, 4'd15, 32'hFFFF_FFFF, 8'd200,
                            pmes_pkg::EFF_RAW, pmes_pkg::ALN_LEFT, 1, 16'hFFFF, 12'd50),
                         0, f});
        f = '{1'b0, 4'd15, 8'd200, pmes_pkg::EFF_RAW, 13'd0, 1'b0};
        rows.push_back('{mk(pmes_pkg::MODE_TICK, 48'd200, 0, 0, 0, 0, 0, 0, 0, 0), 1, f});
        rows.push_back('{mk(pmes_pkg::MODE_SET, 48'd100, 4'd15, 32'd0, 8'd1,
                            pmes_pkg::EFF_FLASH, pmes_pkg::ALN_CENTRE, 0, 16'd0, 12'd7),
                         0, f});
        rows.push_back('{mk(pmes_pkg::MODE_SET, 48'd100, 4'd0, 32'd1000, 8'd9,
                            pmes_pkg::EFF_FLASH, 2'd3, 0, 16'd30, 12'd20), 0, f});
        rows.push_back('{mk(pmes_pkg::MODE_TICK, 48'd100, 0, 0, 0, 0, 0, 0, 0, 0), 0, f});
        rows.push_back('{mk(pmes_pkg::MODE_TICK, 48'd101, 0, 0, 0, 0, 0, 0, 0, 0), 0, f});
        rows.push_back('{mk(pmes_pkg::MODE_TICK, 48'd145, 0, 0, 0, 0, 0, 0, 0, 0), 0, f});
        rows.push_back('{mk(pmes_pkg::MODE_SET, 48'd0, 4'd7, 32'd5000, 8'd255,
                            pmes_pkg::EFF_SCROLL, 0, 0, 16'd0, 12'd10), 0, f});
        rows.push_back('{mk(pmes_pkg::MODE_TICK, 48'd300, 0, 0, 0, 0, 0, 0, 0, 0), 0, f});
        rows.push_back('{mk(pmes_pkg::MODE_SET, 48'd0, 4'd8, 32'd5000, 8'd3,
                            pmes_pkg::EFF_SCROLL, 0, 1, 16'hFFFF, 12'd1), 0, f});
        rows.push_back('{mk(pmes_pkg::MODE_TICK, 48'd333, 0, 0, 0, 0, 0, 0, 0, 0), 0, f});
        rows.push_back('{mk(pmes_pkg::MODE_SET, 48'd0, 4'd9, 32'd5000, 8'd3,
                            pmes_pkg::EFF_SCROLL, 0, 1, 16'd37, 12'd4095), 0, f});
        rows.push_back('{mk(pmes_pkg::MODE_TICK, 48'd4321, 0, 0, 0, 0, 0, 0, 0, 0), 0, f});
        rows.push_back('{mk(2'd3, 48'd1, 0, 0, 8'hFF, 2'd3, 2'd3, 1, 16'hFFFF, 12'hFFF),
                         0, f});
        rows.push_back('{mk(pmes_pkg::MODE_TICK, 48'd9000, 0, 0, 0, 0, 0, 0, 0, 0), 0, f});
        foreach (rows[i])
        begin
            rw = rows[i];
            send(rw.req);
            if (rw.has_fixed)
            begin
                void'(expected_shown.pop_back());
                expected_shown.push_back(rw.fixed);
            end
        end
        drain();

        now_ms = 48'd10000;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin write_reg(pmes_pkg::CFG_MAX_BRIGHT, 10'd0);
                         write_reg(pmes_pkg::CFG_DISP_W, 10'd1); end
                1: begin write_reg(pmes_pkg::CFG_MAX_BRIGHT, 10'd128);
                         write_reg(pmes_pkg::CFG_DISP_W, 10'd1023);
                         send_idle_pct = 77; recv_idle_pct = 8; end
                default: begin write_reg(pmes_pkg::CFG_MAX_BRIGHT, 10'd255);
                               write_reg(pmes_pkg::CFG_DISP_W, 10'($urandom_range(1, 1023)));
                               send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < 360; n++)
            begin
                now_ms = now_ms + $urandom_range(60);
                send(rand_request());
                if (n == 180)
                begin
                    cmd.valid <= 1'b0;
                    while (expected_shown.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("priority_message_effect_scheduler_tb: clean");
        else
            $display("priority_message_effect_scheduler_tb: errors");
        $finish;
    end
endmodule

### priority_message_effect_scheduler.f
+incdir+hdl
hdl/pmes_pkg.sv
hdl/pmes_if.sv
hdl/pmes_slot_store.sv
hdl/pmes_divider.sv
hdl/priority_message_effect_scheduler.sv
sim/priority_message_effect_scheduler_tb.sv
